>>> rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

    // width of the distance result
    localparam int DIST_W = 34;
    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 8;

    typedef enum logic [1:0] {
        PART_START    = 2'd0,
        PART_END      = 2'd1,
        PART_INTERIOR = 2'd2
    } t_part;

    // control that travels beside each word through the back pipeline
    typedef struct packed {
        logic  vld;
        t_part part;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/psd_in_if.sv
`default_nettype none
interface psd_in_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/psd_out_if.sv
`default_nettype none
interface psd_out_if import psd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [1:0]        nearest_part;

    modport source (output valid, distance, nearest_part, input ready);
    modport sink (input valid, distance, nearest_part, output ready);
endinterface
`default_nettype wire

>>> rtl/psd_front.sv
`default_nettype none
module psd_front import psd_pkg::*; #(
    parameter int  COORD_WIDTH = 32,
    localparam int UW          = 2*COORD_WIDTH + 2,
    localparam int NUMW        = 4*COORD_WIDTH + 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_acc,
    input  wire logic signed [COORD_WIDTH-1:0] i_p [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_s [3],
    input  wire logic signed [COORD_WIDTH-1:0] i_e [3],
    output t_ctl                               o_ctl,
    output logic [NUMW-1:0]                    o_num,
    output logic [UW-1:0]                      o_den
);
    localparam int DW  = COORD_WIDTH + 1;  // coordinate differences
    localparam int PW  = 2*DW;             // signed products
    localparam int SW  = PW + 1;           // signed sums of products
    localparam int CAW = SW - 1;           // magnitude of cross components
    localparam int H   = DW;               // low half of a magnitude
    localparam int HW  = CAW - H;          // high half

    logic [5:0] r_vld;

    logic signed [DW-1:0] r_w [3];
    logic signed [DW-1:0] r_v [3];
    logic signed [DW-1:0] r_d [3];

    logic signed [PW-1:0] r_pwd [3];
    logic signed [PW-1:0] r_pdd [3];
    logic signed [PW-1:0] r_pww [3];
    logic signed [PW-1:0] r_pvv [3];
    logic signed [PW-1:0] r_xa  [3];
    logic signed [PW-1:0] r_xb  [3];

    logic signed [SW-1:0] r_t;
    logic signed [SW-1:0] r_c [3];
    logic [UW-1:0]        r_dd3, r_ww3, r_vv3;

    logic [CAW-1:0] r_ca [3];
    logic [UW-1:0]  r_dd4, r_ww4, r_vv4;
    t_part          r_part4;

    logic [2*H-1:0]    r_ll [3];
    logic [H+HW-1:0]   r_lh [3];
    logic [2*HW-1:0]   r_hh [3];
    logic [UW-1:0]     r_dd5, r_ww5, r_vv5;
    t_part             r_part5;

    logic [NUMW-1:0] r_sq [3];
    logic [UW-1:0]   r_dd6, r_ww6, r_vv6;
    t_part           r_part6;

    logic signed [SW-1:0] s_t, s_dd, s_ww, s_vv;
    logic signed [SW-1:0] s_c [3];
    logic signed [SW-1:0] s_dd_ext;
    t_part                n_part4;
    logic [NUMW-1:0]      s_sum;

    // valid shift along the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_acc};
        end
    end

    // stage 1: difference vectors
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_w[i] <= DW'(i_p[i]) - DW'(i_s[i]);
            r_v[i] <= DW'(i_p[i]) - DW'(i_e[i]);
            r_d[i] <= DW'(i_e[i]) - DW'(i_s[i]);
        end
    end

    // stage 2: products for dot and cross products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pwd[i] <= r_w[i] * r_d[i];
            r_pdd[i] <= r_d[i] * r_d[i];
            r_pww[i] <= r_w[i] * r_w[i];
            r_pvv[i] <= r_v[i] * r_v[i];
            r_xa[i]  <= r_w[(i+1)%3] * r_d[(i+2)%3];
            r_xb[i]  <= r_w[(i+2)%3] * r_d[(i+1)%3];
        end
    end

    // stage 3: dot products and cross components
    always_comb begin
        s_t  = SW'(r_pwd[0]) + SW'(r_pwd[1]) + SW'(r_pwd[2]);
        s_dd = SW'(r_pdd[0]) + SW'(r_pdd[1]) + SW'(r_pdd[2]);
        s_ww = SW'(r_pww[0]) + SW'(r_pww[1]) + SW'(r_pww[2]);
        s_vv = SW'(r_pvv[0]) + SW'(r_pvv[1]) + SW'(r_pvv[2]);
        for (int i = 0; i < 3; i++) begin
            s_c[i] = SW'(r_xa[i]) - SW'(r_xb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= s_t;
        r_dd3 <= s_dd[UW-1:0];
        r_ww3 <= s_ww[UW-1:0];
        r_vv3 <= s_vv[UW-1:0];
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= s_c[i];
        end
    end

    // stage 4: classify by the projection, take cross magnitudes
    always_comb begin
        s_dd_ext = $signed({1'b0, r_dd3});
        if (r_dd3 == '0 || r_t[SW-1]) begin
            n_part4 = PART_START;
        end else if (r_t > s_dd_ext) begin
            n_part4 = PART_END;
        end else begin
            n_part4 = PART_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        r_part4 <= n_part4;
        r_dd4   <= r_dd3;
        r_ww4   <= r_ww3;
        r_vv4   <= r_vv3;
        for (int i = 0; i < 3; i++) begin
            r_ca[i] <= r_c[i][SW-1] ? CAW'(-r_c[i]) : CAW'(r_c[i]);
        end
    end

    // stage 5: half-width partial products of the squares
    always_ff @(posedge i_clk) begin
        r_part5 <= r_part4;
        r_dd5   <= r_dd4;
        r_ww5   <= r_ww4;
        r_vv5   <= r_vv4;
        for (int i = 0; i < 3; i++) begin
            r_ll[i] <= r_ca[i][H-1:0] * r_ca[i][H-1:0];
            r_lh[i] <= r_ca[i][H-1:0] * r_ca[i][CAW-1:H];
            r_hh[i] <= r_ca[i][CAW-1:H] * r_ca[i][CAW-1:H];
        end
    end

    // stage 6: assemble the squares
    always_ff @(posedge i_clk) begin
        r_part6 <= r_part5;
        r_dd6   <= r_dd5;
        r_ww6   <= r_ww5;
        r_vv6   <= r_vv5;
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= (NUMW'(r_hh[i]) << (2*H)) + (NUMW'(r_lh[i]) << (H+1))
                     + NUMW'(r_ll[i]);
        end
    end

    // numerator and denominator for the back end
    assign s_sum = r_sq[0] + r_sq[1] + r_sq[2];

    always_comb begin
        unique case (r_part6)
            PART_INTERIOR: begin
                o_num = s_sum;
                o_den = r_dd6;
            end
            PART_END: begin
                o_num = NUMW'(r_vv6);
                o_den = UW'(1);
            end
            default: begin
                o_num = NUMW'(r_ww6);
                o_den = UW'(1);
            end
        endcase
    end

    assign o_ctl.vld  = r_vld[5];
    assign o_ctl.part = r_part6;

endmodule
`default_nettype wire

>>> rtl/psd_queue.sv
`default_nettype none
module psd_queue import psd_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

>>> rtl/psd_div.sv
`default_nettype none
module psd_div import psd_pkg::*; #(
    parameter int NUMW = 132,
    parameter int DDW  = 66,
    parameter int QW   = 66
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_ctl            i_ctl,
    input  wire logic [NUMW-1:0] i_num,
    input  wire logic [DDW-1:0]  i_den,
    output t_ctl                 o_ctl,
    output logic [QW-1:0]        o_q
);
    // one quotient bit per stage, most significant first
    t_ctl            r_ctl [QW+1];
    logic [NUMW-1:0] r_rem [QW+1];
    logic [DDW-1:0]  r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [NUMW:0] s_diff;

        // trial subtract of the shifted divisor
        assign s_diff = {1'b0, r_rem[j]} - {1'b0, (NUMW'(r_den[j]) << K)};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else if (i_en) begin
                r_ctl[j+1] <= r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j+1] <= r_den[j];
                if (!s_diff[NUMW]) begin
                    r_rem[j+1] <= s_diff[NUMW-1:0];
                    r_q[j+1]   <= r_q[j] | (QW'(1) << K);
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_q[j+1]   <= r_q[j];
                end
            end
        end
    end

    assign o_ctl = r_ctl[QW];
    assign o_q   = r_q[QW];

endmodule
`default_nettype wire

>>> rtl/psd_sqrt.sv
`default_nettype none
module psd_sqrt import psd_pkg::*; #(
    parameter int  QW = 66,
    localparam int RW = (QW + 1) / 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_ctl          i_ctl,
    input  wire logic [QW-1:0] i_n,
    output t_ctl               o_ctl,
    output logic [RW-1:0]      o_root
);
    localparam int TW = 2*RW;

    // one root bit per stage, remainder kept as n - root^2
    t_ctl          r_ctl [RW+1];
    logic [TW-1:0] r_rem [RW+1];
    logic [RW-1:0] r_res [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= TW'(i_n);
            r_res[0] <= '0;
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int K = RW - 1 - j;
        logic [TW-1:0] s_trial;
        logic [TW:0]   s_diff;

        // (2*root + 2^k) * 2^k
        assign s_trial = (TW'(r_res[j]) << (K + 1)) | (TW'(1) << (2*K));
        assign s_diff  = {1'b0, r_rem[j]} - {1'b0, s_trial};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else if (i_en) begin
                r_ctl[j+1] <= r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_diff[TW]) begin
                    r_rem[j+1] <= s_diff[TW-1:0];
                    r_res[j+1] <= r_res[j] | (RW'(1) << K);
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_res[j+1] <= r_res[j];
                end
            end
        end
    end

    assign o_ctl  = r_ctl[RW];
    assign o_root = r_res[RW];

endmodule
`default_nettype wire

>>> rtl/point_segment_distance_3d.sv
// Channel   Dir  Handshake      Word
// i_in      in   valid/ready    point, start, end (3 signed coords each)
// o_out     out  valid/ready    distance (34b unsigned), nearest_part (2b)
//
// Accepts one word per cycle while i_in.ready is high. The back end holds the
// one-bit-per-stage divider (2*COORD_WIDTH+2 stages) and square root
// (COORD_WIDTH+1 stages).
// The front runs free; an 8-word queue with credit count sets i_in.ready.
// A stall on o_out freezes the divider and root pipelines and the output reg.
// Reset is synchronous, active low, and clears only valid/control, pointer and count state.
`default_nettype none
module point_segment_distance_3d import psd_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psd_in_if.sink    i_in,
    psd_out_if.source o_out
);
    localparam int UW   = 2*COORD_WIDTH + 2;
    localparam int NUMW = 4*COORD_WIDTH + 4;
    localparam int QW   = 2*COORD_WIDTH + 2;
    localparam int RW   = (QW + 1) / 2;
    localparam int QDW  = 2 + NUMW + UW;
    localparam int UCW  = $clog2(QUEUE_DEPTH + 1);

    logic                          acc;
    logic signed [COORD_WIDTH-1:0] in_p [3];
    logic signed [COORD_WIDTH-1:0] in_s [3];
    logic signed [COORD_WIDTH-1:0] in_e [3];

    t_ctl            f_ctl;
    logic [NUMW-1:0] f_num;
    logic [UW-1:0]   f_den;

    logic [QDW-1:0]  q_data;
    logic            q_empty;
    logic            pop;
    t_ctl            q_ctl;
    logic [NUMW-1:0] q_num;
    logic [UW-1:0]   q_den;

    logic            b_en;
    t_ctl            d_ctl;
    logic [QW-1:0]   d_q;
    t_ctl            s_ctl;
    logic [RW-1:0]   s_root;
    logic [DIST_W-1:0] s_dist;

    logic [UCW-1:0]    r_used;
    logic              r_out_vld;
    logic [DIST_W-1:0] r_dist;
    t_part             r_part;

    // credit: words in the front plus words in the queue
    assign acc      = i_in.valid & i_in.ready;
    assign i_in.ready = (r_used < UCW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + UCW'(acc) - UCW'(pop);
        end
    end

    assign in_p[0] = i_in.point_x;
    assign in_p[1] = i_in.point_y;
    assign in_p[2] = i_in.point_z;
    assign in_s[0] = i_in.start_x;
    assign in_s[1] = i_in.start_y;
    assign in_s[2] = i_in.start_z;
    assign in_e[0] = i_in.end_x;
    assign in_e[1] = i_in.end_y;
    assign in_e[2] = i_in.end_z;

    psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_p     (in_p),
        .i_s     (in_s),
        .i_e     (in_e),
        .o_ctl   (f_ctl),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    psd_queue #(.WIDTH(QDW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_ctl.vld),
        .i_data  ({f_ctl.part, f_num, f_den}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // back end advances whenever the output register can take a word
    assign b_en       = !r_out_vld || o_out.ready;
    assign pop        = b_en && !q_empty;
    assign q_ctl.vld  = !q_empty;
    assign q_ctl.part = t_part'(q_data[QDW-1 -: 2]);
    assign q_num      = q_data[UW +: NUMW];
    assign q_den      = q_data[UW-1:0];

    psd_div #(.NUMW(NUMW), .DDW(UW), .QW(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_en),
        .i_ctl   (q_ctl),
        .i_num   (q_num),
        .i_den   (q_den),
        .o_ctl   (d_ctl),
        .o_q     (d_q)
    );

    psd_sqrt #(.QW(QW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_en),
        .i_ctl   (d_ctl),
        .i_n     (d_q),
        .o_ctl   (s_ctl),
        .o_root  (s_root)
    );

    // saturate the root to the result width
    if (RW > DIST_W) begin : g_sat
        assign s_dist = (|s_root[RW-1:DIST_W]) ? '1 : s_root[DIST_W-1:0];
    end else begin : g_ext
        assign s_dist = DIST_W'(s_root);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (b_en) begin
            r_out_vld <= s_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_dist <= s_dist;
            r_part <= s_ctl.part;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.distance     = r_dist;
    assign o_out.nearest_part = r_part;

    // credit count never passes the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UCW'(QUEUE_DEPTH))
        else $error("credit count above queue depth");

    // a word leaving the front was counted on entry
    a_front_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_ctl.vld |-> r_used != '0)
        else $error("front word without credit");

    // interior words never divide by zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_ctl.vld && f_ctl.part == PART_INTERIOR) |-> f_den != '0)
        else $error("interior word with zero divisor");

    // the queue is only popped when it holds a word
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import psd_pkg::*;

    localparam int CW         = 32;
    localparam int N_RANDOM   = 930;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 150;

    typedef logic signed [159:0] t_wide;

    // one query: point, segment start, segment end
    typedef struct {
        logic signed [CW-1:0] p[3];
        logic signed [CW-1:0] s[3];
        logic signed [CW-1:0] e[3];
    } t_query;

    typedef struct {
        logic [DIST_W-1:0] distance;
        t_part             part;
    } t_answer;

    // directed rows; typed answer used only where fixed is set
    typedef struct {
        t_query  q;
        logic    fixed;
        t_answer ans;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   fail_cnt;
    int   in_taken;
    logic hold_done;

    t_answer answer_q[$];
    t_answer typed_q[$];
    logic    typed_flag_q[$];
    logic    row_fixed;
    t_answer row_ans;

    psd_in_if #(.COORD_WIDTH(CW)) in_ch ();
    psd_out_if                    out_ch ();

    point_segment_distance_3d #(.COORD_WIDTH(CW)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // floor(sqrt(n)), saturated to the distance width
    function automatic logic [DIST_W-1:0] root_floor(input t_wide n);
        t_wide res;
        t_wide cand;
        res = '0;
        for (int k = 52; k >= 0; k--) begin
            cand = res | (t_wide'(1) << k);
            if (cand * cand <= n) res = cand;
        end
        if (res > t_wide'({DIST_W{1'b1}})) res = t_wide'({DIST_W{1'b1}});
        return res[DIST_W-1:0];
    endfunction

    // exact distance from point to segment
    function automatic t_answer segment_distance(input t_query q);
        t_wide   w[3];
        t_wide   v[3];
        t_wide   d[3];
        t_wide   c[3];
        t_wide   proj;
        t_wide   len2;
        t_answer a;
        for (int i = 0; i < 3; i++) begin
            w[i] = t_wide'(q.p[i]) - t_wide'(q.s[i]);
            v[i] = t_wide'(q.p[i]) - t_wide'(q.e[i]);
            d[i] = t_wide'(q.e[i]) - t_wide'(q.s[i]);
        end
        proj = w[0]*d[0] + w[1]*d[1] + w[2]*d[2];
        len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        if (len2 == 0 || proj < 0) begin
            a.distance = root_floor(w[0]*w[0] + w[1]*w[1] + w[2]*w[2]);
            a.part     = PART_START;
        end else if (len2 - proj < 0) begin
            a.distance = root_floor(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]);
            a.part     = PART_END;
        end else begin
            c[0] = w[1]*d[2] - w[2]*d[1];
            c[1] = w[2]*d[0] - w[0]*d[2];
            c[2] = w[0]*d[1] - w[1]*d[0];
            a.distance = root_floor(t_wide'(unsigned'(c[0]*c[0] + c[1]*c[1] + c[2]*c[2])
                                    / unsigned'(len2)));
            a.part     = PART_INTERIOR;
        end
        return a;
    endfunction

    function automatic t_query make_query(
        input logic signed [CW-1:0] px, py, pz, sx, sy, sz, ex, ey, ez);
        t_query q;
        q.p[0] = px; q.p[1] = py; q.p[2] = pz;
        q.s[0] = sx; q.s[1] = sy; q.s[2] = sz;
        q.e[0] = ex; q.e[1] = ey; q.e[2] = ez;
        return q;
    endfunction

    // random query: mostly small geometry, some full range, some degenerate
    function automatic t_query rand_query();
        t_query q;
        int     mode;
        int     sh;
        mode = $urandom_range(0, 9);
        sh   = (mode < 6) ? $urandom_range(8, 30) : 0;
        for (int i = 0; i < 3; i++) begin
            q.p[i] = $signed($urandom()) >>> sh;
            q.s[i] = $signed($urandom()) >>> sh;
            q.e[i] = $signed($urandom()) >>> sh;
            if (mode == 9) q.e[i] = q.s[i];
            if (mode == 8) q.p[i] = q.s[i] + (q.e[i] >>> 1) - (q.s[i] >>> 1);
        end
        return q;
    endfunction

    task automatic send_word(input t_query q);
        in_ch.point_x = q.p[0]; in_ch.point_y = q.p[1]; in_ch.point_z = q.p[2];
        in_ch.start_x = q.s[0]; in_ch.start_y = q.s[1]; in_ch.start_z = q.s[2];
        in_ch.end_x   = q.e[0]; in_ch.end_y   = q.e[1]; in_ch.end_z   = q.e[2];
        in_ch.valid   = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // sender: bursts with random gaps
    initial begin
        t_row rows[$];
        t_row r;
        int   burst;
        logic signed [CW-1:0] mx;
        logic signed [CW-1:0] mn;
        logic signed [CW-1:0] one;
        mx  = {1'b0, {(CW-1){1'b1}}};
        mn  = {1'b1, {(CW-1){1'b0}}};
        one = 32'sh0001_0000;
        in_ch.valid = 1'b0;
        in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
        in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0;
        in_ch.end_x   = '0; in_ch.end_y   = '0; in_ch.end_z   = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // all zero
        r.q = make_query(0,0,0, 0,0,0, 0,0,0);
        r.fixed = 1; r.ans = '{0, PART_START}; rows.push_back(r);
        // degenerate segment
        r.q = make_query(one,0,0, 0,0,0, 0,0,0);
        r.fixed = 1; r.ans = '{65536, PART_START}; rows.push_back(r);
        // before start
        r.q = make_query(-2*one,0,0, 0,0,0, one,0,0);
        r.fixed = 1; r.ans = '{131072, PART_START}; rows.push_back(r);
        // past end
        r.q = make_query(3*one,0,0, 0,0,0, one,0,0);
        r.fixed = 1; r.ans = '{131072, PART_END}; rows.push_back(r);
        // interior
        r.q = make_query(0,one,0, -one,0,0, one,0,0);
        r.fixed = 1; r.ans = '{65536, PART_INTERIOR}; rows.push_back(r);
        // projection exactly on the start
        r.q = make_query(0,0,one, 0,0,0, 0,one,0);
        r.fixed = 1; r.ans = '{65536, PART_INTERIOR}; rows.push_back(r);
        // projection exactly on the end
        r.q = make_query(one,one,0, 0,0,0, one,0,0);
        r.fixed = 1; r.ans = '{65536, PART_INTERIOR}; rows.push_back(r);
        // extremes and two small cases, checked against the predictor
        r.fixed = 0;
        r.q = make_query(mx,mx,mx, mn,mn,mn, mn,mn,mn); rows.push_back(r);
        r.q = make_query(mn,mn,mn, mx,mx,mx, mx,mx,mx); rows.push_back(r);
        r.q = make_query(mx,mx,mx, mn,mn,mn, mx,mx,mx); rows.push_back(r);
        r.q = make_query(mn,mx,mn, mn,mn,mn, mx,mx,mx); rows.push_back(r);
        r.q = make_query(mx,mn,0, mx,mn,mx, mn,mx,mn); rows.push_back(r);
        r.q = make_query(0,0,0, mn,mx,mn, mx,mn,mx); rows.push_back(r);
        r.q = make_query(mn,mn,mn, mn,mn,mn, mx,mx,mx); rows.push_back(r);
        r.q = make_query(-1,-1,-1, 1,1,1, -1,-1,-1); rows.push_back(r);
        r.q = make_query(1,0,0, 0,0,0, 0,0,1); rows.push_back(r);

        foreach (rows[i]) begin
            typed_flag_q.push_back(rows[i].fixed);
            typed_q.push_back(rows[i].ans);
            send_word(rows[i].q);
        end
        for (int n = 0; n < N_RANDOM; n += burst) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
            for (int b = 0; b < burst; b++) begin
                typed_flag_q.push_back(1'b0);
                typed_q.push_back('{0, PART_START});
                send_word(rand_query());
            end
        end

        // drain
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin
        int mode;
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && in_taken >= 300) begin
                hold_done    = 1'b1;
                out_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            mode = (cycle_cnt / 256) % 4;
            case (mode)
                0: begin
                    out_ch.ready = 1'b1;
                end
                1: begin
                    out_ch.ready = ($urandom_range(0, 3) != 0);
                end
                2: begin
                    out_ch.ready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    out_ch.ready = ((cycle_cnt % 7) < 4);
                end
            endcase
        end
    end

    // prediction on input words, checking on output words
    always @(posedge i_clk) begin
        t_answer exp_ans;
        t_answer got;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            exp_ans = segment_distance(make_query(
                in_ch.point_x, in_ch.point_y, in_ch.point_z,
                in_ch.start_x, in_ch.start_y, in_ch.start_z,
                in_ch.end_x, in_ch.end_y, in_ch.end_z));
            row_fixed = typed_flag_q.pop_front();
            row_ans   = typed_q.pop_front();
            if (row_fixed) exp_ans = row_ans;
            answer_q.push_back(exp_ans);
            in_taken <= in_taken + 1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.distance = out_ch.distance;
            got.part     = t_part'(out_ch.nearest_part);
            if (answer_q.size() == 0) begin
                $error("unexpected word: distance %0d nearest_part %0d",
                       got.distance, got.part);
                fail_cnt = fail_cnt + 1;
            end else begin
                exp_ans = answer_q.pop_front();
                if (got.distance !== exp_ans.distance) begin
                    $error("distance: expected %0d, actual %0d",
                           exp_ans.distance, got.distance);
                    fail_cnt = fail_cnt + 1;
                end
                if (out_ch.nearest_part !== exp_ans.part) begin
                    $error("nearest_part: expected %0d, actual %0d",
                           exp_ans.part, out_ch.nearest_part);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        fail_cnt  = 0;
        in_taken  = 0;
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
`default_nettype wire
